FILE: src/isort_pkg.sv
// Shared types for the insertion sorter: data word and the command/status
// structs between controller and datapath. No dependencies.
package isort_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] value_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic insert;   // take the request value into the cell array
        logic pop;      // head cell delivered, shift the array down
    } isort_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic one_left; // exactly one stored entry remains
    } isort_stat_t;

endpackage

FILE: src/isort_datapath.sv
// Cell array, fill count and drop flag of the insertion sorter.
// Depends on isort_pkg for the data type and command/status structs.
module isort_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  isort_pkg::isort_cmd_t  cmd,
    input  isort_pkg::value_t    in_value,
    output isort_pkg::isort_stat_t stat,
    output isort_pkg::value_t    head_value,
    output logic                 dropped
);
    import isort_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    value_t           cell_reg [DEPTH];
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic [DEPTH-1:0] gt;
    logic [DEPTH-1:0] wr_en;
    logic             full;

    assign full = (fill_reg == CNT_W'(DEPTH));

    // Each occupied cell compares its own entry with the new value
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            gt[i] = (fill_reg > CNT_W'(i)) && (cell_reg[i] > in_value);
        end
    end

    // A cell is written when its entry moves up or when it is the first free cell
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            wr_en[i] = cmd.insert && !full && (gt[i] || (fill_reg == CNT_W'(i)));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (wr_en[i])
                begin
                    if (i > 0 && gt[(i > 0) ? i - 1 : 0])
                        cell_reg[i] <= cell_reg[(i > 0) ? i - 1 : 0];
                    else
                        cell_reg[i] <= in_value;
                end
            end
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                cell_reg[i] <= cell_reg[i + 1];
            end
        end
    end

    always_comb
    begin
        fill_next    = fill_reg;
        dropped_next = dropped_reg;
        if (cmd.insert)
        begin
            if (full)
                dropped_next = 1'b1;
            else
                fill_next = fill_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            fill_next = fill_reg - CNT_W'(1);
            // clear the drop mark once the set is fully delivered
            if (fill_reg == CNT_W'(1))
                dropped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            fill_reg    <= fill_next;
            dropped_reg <= dropped_next;
        end
    end

    assign stat.one_left = (fill_reg == CNT_W'(1));
    assign head_value    = cell_reg[0];
    assign dropped       = dropped_reg;

endmodule

FILE: src/isort_ctrl.sv
// Controller of the insertion sorter: fill and emit phases, handshakes.
// Depends on isort_pkg for the command/status structs.
module isort_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_last,
    input  logic                   out_ready,
    input  isort_pkg::isort_stat_t stat,
    output logic                   in_ready,
    output logic                   out_valid,
    output isort_pkg::isort_cmd_t  cmd
);
    import isort_pkg::*;

    typedef enum logic [0:0] {
        ST_FILL,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   deliver;

    assign accept  = in_valid && in_ready_reg;
    assign deliver = out_valid_reg && out_ready;

    always_comb
    begin
        state_next     = state_reg;
        in_ready_next  = in_ready_reg;
        out_valid_next = out_valid_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (accept && in_last)
                begin
                    state_next     = ST_EMIT;
                    in_ready_next  = 1'b0;
                    out_valid_next = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (deliver && stat.one_left)
                begin
                    state_next     = ST_FILL;
                    in_ready_next  = 1'b1;
                    out_valid_next = 1'b0;
                end
            end
            default:
            begin
                state_next     = ST_FILL;
                in_ready_next  = 1'b1;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready   = in_ready_reg;
    assign out_valid  = out_valid_reg;
    assign cmd.insert = accept;
    assign cmd.pop    = deliver;

endmodule

FILE: src/insertion_sorter_core.sv
// Insertion sorter: while filling, one request is taken per cycle and every
// occupied cell compares it with its own entry in parallel. A request with
// tlast closes the set; the next cycle the sorted values leave in ascending
// order, one per cycle while m_tready is high, and no request is taken until
// the last one is delivered. Values beyond DEPTH are dropped and m_tuser is
// set on every result of that set. Equal values keep arrival order.
module insertion_sorter_core #(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic signed [31:0]       s_tdata,   // [31:0] value
    input  logic                     s_tlast,   // last_item
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic signed [31:0]       m_tdata,   // [31:0] sorted_value
    output logic                     m_tlast,   // last_result
    output logic                     m_tuser    // [0] overflow
);
    import isort_pkg::*;

    isort_cmd_t  cmd;
    isort_stat_t stat;
    value_t      head_value;
    logic        dropped;

    isort_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .out_ready (m_tready),
        .stat      (stat),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .cmd       (cmd)
    );

    isort_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_value   (s_tdata),
        .stat       (stat),
        .head_value (head_value),
        .dropped    (dropped)
    );

    assign m_tdata = head_value;
    assign m_tlast = stat.one_left;
    assign m_tuser = dropped;

    // Fill and emit phases never overlap
    a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output open at the same time");

    a_last_starts_emit: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("closing request did not start emission");

    a_emit_continues: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("emission stopped before the last result");

    a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tuser)
        else $error("set not closed after the last result");

endmodule

FILE: test/tb_insertion_sorter_core.sv
`timescale 1ns / 100ps
// Testbench for insertion_sorter_core: streams signed sets in, predicts the
// sorted output of each set and checks every result. Depends on isort_pkg.
module tb_insertion_sorter_core;

    import isort_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = DEPTH + 8;

    typedef struct packed {
        value_t value;
        logic   last;
        logic   overflow;
    } sorted_word_t;

    logic   clk;
    logic   rst_n;
    logic   s_tvalid;
    logic   s_tready;
    value_t s_tdata;    // [31:0] value
    logic   s_tlast;    // last_item
    logic   m_tvalid;
    logic   m_tready;
    value_t m_tdata;    // [31:0] sorted_value
    logic   m_tlast;    // last_result
    logic   m_tuser;    // [0] overflow

    // Predicted store contents
    value_t       sort_cells [DEPTH];
    int           sort_fill;
    logic         sort_dropped;
    sorted_word_t sorted_due [$];

    int   error_count;
    int   cycle_count;
    int   hold_request;
    int   hold_left;
    int   stall_left;
    logic steady;

    insertion_sorter_core #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Insert one accepted request; a last request closes the set
    task automatic record_request(input value_t v, input logic last);
        int pos;
        sorted_word_t word;
        if (sort_fill >= DEPTH)
        begin
            sort_dropped = 1'b1;
        end
        else
        begin
            pos = sort_fill;
            while (pos > 0 && sort_cells[pos-1] > v)
            begin
                sort_cells[pos] = sort_cells[pos-1];
                pos--;
            end
            sort_cells[pos] = v;
            sort_fill++;
        end
        if (last)
        begin
            for (int k = 0; k < sort_fill; k++)
            begin
                word.value    = sort_cells[k];
                word.last     = (k == sort_fill - 1);
                word.overflow = sort_dropped;
                sorted_due.push_back(word);
            end
            sort_fill    = 0;
            sort_dropped = 1'b0;
        end
    endtask

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic value_t pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3: return value_t'($urandom_range(0, 7)) - 4;
            default: return value_t'($urandom);
        endcase
    endfunction

    // Offer one request from a falling edge and hold it until taken
    task automatic send_request(input value_t v, input logic last);
        int gap;
        gap = gap_cycles();
        repeat (gap) @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = v;
        s_tlast  = last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        record_request(v, last);
        @(negedge clk);
        s_tvalid = 1'b0;
        s_tdata  = value_t'($urandom);
        s_tlast  = 1'($urandom_range(0, 1));
    endtask

    task automatic send_set(input int len);
        for (int i = 0; i < len; i++)
            send_request(pick_value(), i == len - 1);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready = 1'b0;
        end
        else if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
            m_tready     = 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready = 1'b0;
        end
        else
        begin
            m_tready   = 1'b1;
            stall_left = steady ? 0 : gap_cycles();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (sorted_due.size() == 0)
            begin
                $display("%0t: unexpected result value=%0d last=%b overflow=%b",
                         $time, m_tdata, m_tlast, m_tuser);
                error_count++;
            end
            else
            begin
                if (m_tdata !== sorted_due[0].value)
                begin
                    $display("%0t: sorted_value expected %0d actual %0d",
                             $time, sorted_due[0].value, m_tdata);
                    error_count++;
                end
                if (m_tlast !== sorted_due[0].last)
                begin
                    $display("%0t: last_result expected %b actual %b",
                             $time, sorted_due[0].last, m_tlast);
                    error_count++;
                end
                if (m_tuser !== sorted_due[0].overflow)
                begin
                    $display("%0t: overflow expected %b actual %b",
                             $time, sorted_due[0].overflow, m_tuser);
                    error_count++;
                end
                void'(sorted_due.pop_front());
            end
        end
    end

    task automatic test_extremes();
        send_request(32'sh7FFF_FFFF, 1'b0);
        send_request(32'sh8000_0000, 1'b0);
        send_request(32'sh0000_0000, 1'b0);
        send_request(-32'sd1, 1'b1);
    endtask

    task automatic test_single_and_ties();
        send_request(32'sh8000_0000, 1'b1);
        send_request(32'sd7, 1'b0);
        send_request(32'sd7, 1'b0);
        send_request(-32'sd3, 1'b1);
    endtask

    // Fill the store, then drop the closing request itself
    task automatic test_overflow();
        for (int i = 0; i < DEPTH; i++)
            send_request(value_t'(DEPTH - i) * 32'sd1000 - 32'sd9000, 1'b0);
        send_request(32'sh7FFF_FFFF, 1'b1);
    endtask

    task automatic test_random_sets();
        int sent;
        int len;
        int set_index;
        sent      = 0;
        set_index = 0;
        while (sent < 85)
        begin
            steady = (set_index % 5 == 4);
            if ($urandom_range(0, 5) == 0)
                len = $urandom_range(DEPTH + 1, DEPTH + 4);
            else
                len = $urandom_range(1, DEPTH);
            send_set(len);
            sent += len;
            set_index++;
        end
        steady = 1'b0;
    endtask

    // Hold the output off so the block stalls its input behind a full set
    task automatic test_output_backpressure();
        hold_request = 300;
        send_set(DEPTH);
        send_set(6);
    endtask

    initial
    begin
        error_count  = 0;
        cycle_count  = 0;
        hold_request = 0;
        hold_left    = 0;
        stall_left   = 0;
        steady       = 1'b0;
        sort_fill    = 0;
        sort_dropped = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_single_and_ties();
        test_overflow();
        test_random_sets();
        test_output_backpressure();

        while (sorted_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
